FILE: src/bfa_pkg.sv
// Shared types and constants for the bitmap fit allocator.
`default_nettype none
package bfa_pkg;

  localparam int unsigned SIZE_W      = 11;
  localparam int unsigned START_W     = 10;
  localparam int unsigned HOLE_W      = 10;
  localparam int unsigned UNITS_W     = 11;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_USED_W  = START_W + HOLE_W + UNITS_W + UNITS_W;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_STATS = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_WORST = 2'd1,
    POL_FIRST = 2'd2,
    POL_NONE  = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    CMD_NOP   = 3'd0,
    CMD_FAIL  = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_ALLOC = 3'd3,
    CMD_STATS = 3'd4
  } cmd_kind_t;

  // size is the allocation size, or the clamped unit count of a free
  typedef struct packed {
    cmd_kind_t          kind;
    policy_t            policy;
    logic [SIZE_W-1:0]  size;
    logic [START_W-1:0] start;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] alloc_start;
    logic [HOLE_W-1:0]  hole_count;
    logic [UNITS_W-1:0] free_units;
    logic [UNITS_W-1:0] used_units;
  } result_t;

endpackage
`default_nettype wire

FILE: src/bitmap_fit_allocator.sv
// Contiguous fit allocator over a one-bit-per-unit occupancy bitmap.
//
// Requests enter on the in_ stream: in_tuser carries the operation (allocate,
// free range, statistics), in_tdata the size and the free start. Every request
// yields exactly one result on the out_ stream, in request order: out_tuser is
// the found flag, out_tdata carries the allocated start and the statistics.
// cfg_wr_en/cfg_wr_data set the placement policy (best, worst, first fit).
// Intake decodes a request into its hold register and parks it in a two-entry
// queue, so up to three requests are taken while the engine is busy. The
// engine walks the bitmap memory one unit per cycle; from taking a request to
// its result:
//   allocate and statistics: a scan of the whole memory; a found run is then marked unit by unit
//   free: a sweep over the freed units (clamped at the end of memory)
//   no-op, zero size or failing policy: straight to the result
// Intake and the queue sit in front. The engine takes no new request until
// its last result has gone into the output register.
// After reset a clearing pass writes every unit free, with in_tready low; the
// policy resets to first fit. A result waits in the output register while
// out_tready is low; the engine holds its next result until the register
// frees, and intake keeps filling the queue meanwhile.
`default_nettype none
module bitmap_fit_allocator #(
  parameter int unsigned MEM_UNITS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [10:0] req_size, [20:11] free_start, [23:21] zero
  input  wire logic [bfa_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] op
  input  wire logic [bfa_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [9:0] alloc_start, [19:10] hole_count, [30:20] free_units,
  // [41:31] used_units, [47:42] zero
  output logic [bfa_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] found
  output logic                                  out_tuser,
  input  wire logic                             cfg_wr_en,
  input  wire logic [1:0]                       cfg_wr_data
);

  logic          init_done;
  logic          push_valid;
  logic          push_ready;
  bfa_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  bfa_pkg::cmd_t pop_cmd;

  bfa_front #(
    .MEM_UNITS(MEM_UNITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .init_done  (init_done),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  bfa_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  bfa_engine #(
    .MEM_UNITS(MEM_UNITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .init_done (init_done)
  );

endmodule
`default_nettype wire

FILE: src/bfa_front.sv
// Request intake: policy register, decode and free-range clamping.
`default_nettype none
module bfa_front #(
  parameter int unsigned MEM_UNITS = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bfa_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [bfa_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                              cfg_wr_en,
  input  wire logic [1:0]                        cfg_wr_data,
  input  wire logic                              init_done,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output bfa_pkg::cmd_t                          push_cmd
);

  localparam int unsigned AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int unsigned EW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam logic [EW-1:0] UNITS_E = EW'(MEM_UNITS);

  bfa_pkg::policy_t              policy_r;
  logic                          hold_valid_r;
  bfa_pkg::cmd_t                 hold_cmd_r;
  bfa_pkg::cmd_t                 cmd_nxt;
  bfa_pkg::op_t                  op;
  logic [bfa_pkg::SIZE_W-1:0]    size;
  logic [bfa_pkg::START_W-1:0]   start;
  logic [EW-1:0]                 start_e;
  logic [EW-1:0]                 end_e;
  logic [EW-1:0]                 lim_e;
  logic [EW-1:0]                 cnt_e;
  logic                          accept;

  assign op        = bfa_pkg::op_t'(in_tuser);
  assign size      = in_tdata[bfa_pkg::SIZE_W-1:0];
  assign start     = in_tdata[bfa_pkg::SIZE_W +: bfa_pkg::START_W];
  assign start_e   = EW'(start);
  assign end_e     = start_e + EW'(size);
  assign lim_e     = (end_e > UNITS_E) ? UNITS_E : end_e;
  assign cnt_e     = lim_e - start_e;
  assign in_tready = init_done & (~hold_valid_r | push_ready);
  assign accept    = in_tvalid & in_tready;
  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_cmd_r;

  always_comb begin
    cmd_nxt        = '0;
    cmd_nxt.kind   = bfa_pkg::CMD_NOP;
    cmd_nxt.policy = policy_r;
    cmd_nxt.size   = size;
    cmd_nxt.start  = start;
    unique case (op)
      bfa_pkg::OP_ALLOC: begin
        if (size == '0 || policy_r == bfa_pkg::POL_NONE) begin
          cmd_nxt.kind = bfa_pkg::CMD_FAIL;
        end else begin
          cmd_nxt.kind = bfa_pkg::CMD_ALLOC;
        end
      end
      bfa_pkg::OP_FREE: begin
        // clamp the range at the end of memory; empty ranges do nothing
        if (size != '0 && start_e < UNITS_E) begin
          cmd_nxt.kind = bfa_pkg::CMD_FREE;
          cmd_nxt.size = cnt_e[bfa_pkg::SIZE_W-1:0];
        end
      end
      bfa_pkg::OP_STATS: cmd_nxt.kind = bfa_pkg::CMD_STATS;
      default:           cmd_nxt.kind = bfa_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= bfa_pkg::POL_FIRST;
      hold_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy_r <= bfa_pkg::policy_t'(cfg_wr_data);
      end
      if (accept) begin
        hold_valid_r <= 1'b1;
        hold_cmd_r   <= cmd_nxt;
      end else if (push_ready) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/bfa_cmd_fifo.sv
// Two-entry command queue between intake and the bitmap engine.
`default_nettype none
module bfa_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire bfa_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output bfa_pkg::cmd_t      pop_cmd
);

  localparam int unsigned DEPTH = 2;

  bfa_pkg::cmd_t entries_r [DEPTH];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        entries_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r            <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/bfa_engine.sv
// Bitmap engine: occupancy memory, scan, mark/free sweeps and result register.
`default_nettype none
module bfa_engine #(
  parameter int unsigned MEM_UNITS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire bfa_pkg::cmd_t                    cmd,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [bfa_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tuser,
  output logic                                  init_done
);

  localparam int unsigned AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int unsigned LW = AW + 1;
  localparam int unsigned CW = (LW > 11) ? LW : 11;
  localparam logic [LW-1:0] UNITS_L = LW'(MEM_UNITS);
  localparam logic [AW-1:0] LAST_A  = AW'(MEM_UNITS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_REPLY
  } state_t;

  state_t                      state_r;
  bfa_pkg::cmd_t               cmd_r;
  logic [AW-1:0]               addr_r;
  logic [bfa_pkg::SIZE_W-1:0]  cnt_r;
  logic [LW-1:0]               scan_r;
  logic                        stg_valid_r;
  logic [LW-1:0]               stg_pos_r;
  logic [LW-1:0]               run_len_r, run_len_nxt;
  logic [AW-1:0]               run_start_r, run_start_nxt;
  logic                        have_r, have_nxt;
  logic [AW-1:0]               pick_start_r, pick_start_nxt;
  logic [LW-1:0]               pick_len_r, pick_len_nxt;
  logic [LW-1:0]               hole_r, hole_nxt;
  logic [LW-1:0]               free_r, free_nxt;
  bfa_pkg::result_t            res_r;
  bfa_pkg::result_t            res_init;
  logic                        out_valid_r;
  bfa_pkg::result_t            out_data_r;

  logic                        mem_q [MEM_UNITS];
  logic                        rdata_r;
  logic                        mem_we;
  logic                        mem_wdata;
  logic [AW-1:0]               mem_raddr;

  logic                        unit_free;
  logic                        scan_last;
  logic                        run_fits;
  logic                        take;
  logic                        out_free;
  logic [CW-1:0]               start_ext;
  logic [CW-1:0]               pick_ext;
  logic [CW-1:0]               hole_ext;
  logic [CW-1:0]               free_ext;
  logic [CW-1:0]               used_ext;

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_MARK) || (state_r == S_FREE);
  assign mem_wdata = (state_r == S_MARK);
  assign mem_raddr = (scan_r < UNITS_L) ? scan_r[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[addr_r] <= mem_wdata;
    end
    rdata_r <= mem_q[mem_raddr];
  end

  // The position one past the end counts as used, closing the final run.
  assign scan_last = stg_valid_r && (stg_pos_r == UNITS_L);
  assign unit_free = stg_valid_r && (stg_pos_r != UNITS_L) && !rdata_r;
  assign run_fits  = (CW'(run_len_r) >= CW'(cmd_r.size));
  assign take      = run_fits &&
                     (!have_r ||
                      (cmd_r.policy == bfa_pkg::POL_BEST  && run_len_r < pick_len_r) ||
                      (cmd_r.policy == bfa_pkg::POL_WORST && run_len_r > pick_len_r));

  always_comb begin
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    have_nxt       = have_r;
    pick_start_nxt = pick_start_r;
    pick_len_nxt   = pick_len_r;
    hole_nxt       = hole_r;
    free_nxt       = free_r;
    if (stg_valid_r) begin
      if (unit_free) begin
        if (run_len_r == '0) begin
          run_start_nxt = stg_pos_r[AW-1:0];
          hole_nxt      = hole_r + LW'(1);
        end
        run_len_nxt = run_len_r + LW'(1);
        free_nxt    = free_r + LW'(1);
      end else begin
        if (take) begin
          have_nxt       = 1'b1;
          pick_start_nxt = run_start_r;
          pick_len_nxt   = run_len_r;
        end
        run_len_nxt = '0;
      end
    end
  end

  // frees and no-ops answer found; allocations start out not found
  always_comb begin
    res_init       = '0;
    res_init.found = (cmd.kind != bfa_pkg::CMD_FAIL) && (cmd.kind != bfa_pkg::CMD_ALLOC);
  end

  assign start_ext = CW'(cmd.start);
  assign pick_ext  = CW'(pick_start_nxt);
  assign hole_ext  = CW'(hole_nxt);
  assign free_ext  = CW'(free_nxt);
  assign used_ext  = CW'(UNITS_L - free_nxt);

  assign cmd_ready  = (state_r == S_IDLE);
  assign init_done  = (state_r != S_CLEAR);
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.found;
  assign out_tdata  = {{(bfa_pkg::OUT_TDATA_W - bfa_pkg::OUT_USED_W){1'b0}},
                       out_data_r.used_units, out_data_r.free_units,
                       out_data_r.hole_count, out_data_r.alloc_start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_REPLY && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      stg_valid_r <= (state_r == S_SCAN) && !scan_last;
      unique case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == LAST_A) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            res_r <= res_init;
            unique case (cmd.kind)
              bfa_pkg::CMD_FAIL: begin
                state_r <= S_REPLY;
              end
              bfa_pkg::CMD_FREE: begin
                addr_r  <= start_ext[AW-1:0];
                cnt_r   <= cmd.size;
                state_r <= S_FREE;
              end
              bfa_pkg::CMD_ALLOC, bfa_pkg::CMD_STATS: begin
                scan_r    <= '0;
                run_len_r <= '0;
                have_r    <= 1'b0;
                hole_r    <= '0;
                free_r    <= '0;
                state_r   <= S_SCAN;
              end
              default: begin
                state_r <= S_REPLY;
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue the next read; the stage register meets its data next cycle
          stg_pos_r    <= scan_r;
          scan_r       <= scan_r + LW'(1);
          run_len_r    <= run_len_nxt;
          run_start_r  <= run_start_nxt;
          have_r       <= have_nxt;
          pick_start_r <= pick_start_nxt;
          pick_len_r   <= pick_len_nxt;
          hole_r       <= hole_nxt;
          free_r       <= free_nxt;
          if (scan_last) begin
            if (cmd_r.kind == bfa_pkg::CMD_STATS) begin
              res_r.found      <= 1'b1;
              res_r.hole_count <= hole_ext[bfa_pkg::HOLE_W-1:0];
              res_r.free_units <= free_ext[bfa_pkg::UNITS_W-1:0];
              res_r.used_units <= used_ext[bfa_pkg::UNITS_W-1:0];
              state_r          <= S_REPLY;
            end else if (have_nxt) begin
              res_r.found       <= 1'b1;
              res_r.alloc_start <= pick_ext[bfa_pkg::START_W-1:0];
              addr_r            <= pick_start_nxt;
              cnt_r             <= cmd_r.size;
              state_r           <= S_MARK;
            end else begin
              state_r <= S_REPLY;
            end
          end
        end
        S_MARK, S_FREE: begin
          addr_r <= addr_r + AW'(1);
          cnt_r  <= cnt_r - bfa_pkg::SIZE_W'(1);
          if (cnt_r == bfa_pkg::SIZE_W'(1)) begin
            state_r <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/bfa_checker.sv
// Port-level checks for the allocator, bound to the top level.
`default_nettype none
module bfa_checker #(
  parameter int unsigned MEM_UNITS = 1024
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [bfa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                             out_tuser
);

  // the clearing pass keeps intake closed right after reset
  a_clear_blocks_intake: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during clearing pass");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_miss_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[9:0] == 10'd0)
    else $error("failed allocation carries a start");

  // statistics add up to the memory size; other results carry no counts
  a_units_balance: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (11'(out_tdata[30:20] + out_tdata[41:31]) == 11'(MEM_UNITS)) ||
      (out_tdata[30:20] == 11'd0 && out_tdata[41:31] == 11'd0))
    else $error("free and used units disagree");

endmodule

bind bitmap_fit_allocator bfa_checker #(
  .MEM_UNITS(MEM_UNITS)
) u_bfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire

FILE: tb/bitmap_fit_allocator_tb.sv
// Self-checking testbench for the bitmap fit allocator: directed table, then random requests.
module bitmap_fit_allocator_tb;

  localparam int MEM_UNITS = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bfa_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [bfa_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [bfa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  bitmap_fit_allocator #(.MEM_UNITS(MEM_UNITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  typedef struct packed {
    bit                          set_pol;
    bfa_pkg::policy_t            pol;
    bfa_pkg::op_t                op;
    logic [bfa_pkg::SIZE_W-1:0]  size;
    logic [bfa_pkg::START_W-1:0] start;
    bit                          typed;
    bfa_pkg::result_t            want;
  } dir_row_t;

  // Shadow of the occupancy bitmap and the placement policy
  bit [MEM_UNITS-1:0] occ_map;
  bfa_pkg::policy_t fit_sel;

  bfa_pkg::result_t awaited_replies[$];
  dir_row_t dir_rows[$];
  int live_start[$];
  int live_size[$];
  int errors = 0;
  bit calm = 1'b0;
  int n_placed = 0, n_refused = 0, n_free = 0, n_stats = 0, n_nop = 0, n_pol_writes = 0;

  always #6 clk = ~clk;

  initial begin
    #(12 * 8_000_000);
    $display("bitmap_fit_allocator regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 7);
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare each returned result with the oldest outstanding expectation
  always @(posedge clk) begin
    bfa_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("found", 32'(want.found), 32'(out_tuser));
        check_field("alloc_start", 32'(want.alloc_start), 32'(out_tdata[9:0]));
        check_field("hole_count", 32'(want.hole_count), 32'(out_tdata[19:10]));
        check_field("free_units", 32'(want.free_units), 32'(out_tdata[30:20]));
        check_field("used_units", 32'(want.used_units), 32'(out_tdata[41:31]));
      end
    end
  end

  // Apply one request to the shadow bitmap and return the reply it earns
  function automatic bfa_pkg::result_t bitmap_apply(bfa_pkg::op_t op, int size, int start);
    bfa_pkg::result_t r;
    int run_start, run_len, pick_start, pick_len, holes, free_cnt;
    bit have, in_hole;
    r = '0;
    r.found = 1'b1;
    have = 1'b0;
    run_start = 0;
    run_len = 0;
    pick_start = 0;
    pick_len = 0;
    case (op)
      bfa_pkg::OP_ALLOC: begin
        if (size != 0 && fit_sel != bfa_pkg::POL_NONE) begin
          for (int i = 0; i <= MEM_UNITS; i++) begin
            if (i < MEM_UNITS && !occ_map[i]) begin
              if (run_len == 0) run_start = i;
              run_len++;
            end else begin
              if (run_len >= size) begin
                if (!have || (fit_sel == bfa_pkg::POL_BEST && run_len < pick_len) ||
                    (fit_sel == bfa_pkg::POL_WORST && run_len > pick_len)) begin
                  pick_start = run_start;
                  pick_len = run_len;
                end
                have = 1'b1;
              end
              run_len = 0;
            end
          end
        end
        if (have) begin
          for (int i = pick_start; i < pick_start + size && i < MEM_UNITS; i++) begin
            occ_map[i] = 1'b1;
          end
          r.alloc_start = bfa_pkg::START_W'(pick_start);
        end else begin
          r.found = 1'b0;
        end
      end
      bfa_pkg::OP_FREE: begin
        for (int i = start; i < start + size && i < MEM_UNITS; i++) occ_map[i] = 1'b0;
      end
      bfa_pkg::OP_STATS: begin
        holes = 0;
        free_cnt = 0;
        in_hole = 1'b0;
        for (int i = 0; i < MEM_UNITS; i++) begin
          if (!occ_map[i]) begin
            free_cnt++;
            if (!in_hole) holes++;
            in_hole = 1'b1;
          end else begin
            in_hole = 1'b0;
          end
        end
        r.hole_count = bfa_pkg::HOLE_W'(holes);
        r.free_units = bfa_pkg::UNITS_W'(free_cnt);
        r.used_units = bfa_pkg::UNITS_W'(MEM_UNITS - free_cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one request, hold it until taken, then predict its reply
  task automatic issue(input bfa_pkg::op_t op, input int size, input int start,
                       output bfa_pkg::result_t r);
    logic [bfa_pkg::SIZE_W-1:0] sz;
    logic [bfa_pkg::START_W-1:0] st;
    sz = bfa_pkg::SIZE_W'(size);
    st = bfa_pkg::START_W'(start);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, st, sz};
    do @(posedge clk); while (!in_tready);
    r = bitmap_apply(op, int'(sz), int'(st));
    case (op)
      bfa_pkg::OP_ALLOC: if (r.found) n_placed++; else n_refused++;
      bfa_pkg::OP_FREE:  n_free++;
      bfa_pkg::OP_STATS: n_stats++;
      default:           n_nop++;
    endcase
  endtask

  task automatic maybe_gap();
    int gap;
    if (!calm && $urandom_range(0, 99) < 7) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(9, 1200);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(bfa_pkg::policy_t p);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fit_sel = p;
    n_pol_writes++;
  endtask

  task automatic add_row(bit set_pol, bfa_pkg::policy_t pol, bfa_pkg::op_t op, int size,
                         int start, bit typed, int found, int a_start, int holes,
                         int free_u, int used_u);
    dir_row_t row;
    row.set_pol = set_pol;
    row.pol = pol;
    row.op = op;
    row.size = bfa_pkg::SIZE_W'(size);
    row.start = bfa_pkg::START_W'(start);
    row.typed = typed;
    row.want.found = 1'(found);
    row.want.alloc_start = bfa_pkg::START_W'(a_start);
    row.want.hole_count = bfa_pkg::HOLE_W'(holes);
    row.want.free_units = bfa_pkg::UNITS_W'(free_u);
    row.want.used_units = bfa_pkg::UNITS_W'(used_u);
    dir_rows.push_back(row);
  endtask

  initial begin
    bfa_pkg::result_t r;
    bfa_pkg::op_t op;
    int size, start, pick, idx, phase_len;
    bfa_pkg::policy_t phase_pol;

    occ_map = '0;
    fit_sel = bfa_pkg::POL_FIRST;

    //      pol   policy             op                 size  start typed fnd a  h  free  used
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_STATS, 1,    0,    1, 1, 0, 1, 1024, 0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 0,    0,    1, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 1025, 0,    1, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 2047, 1023, 1, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 1,    0,    1, 1, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 1023, 0,    1, 1, 1, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 1,    0,    1, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_STATS, 1,    0,    1, 1, 0, 0, 0,    1024);
    // free past the end of memory clears only the last unit
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  2047, 1023, 1, 1, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  0,    5,    1, 1, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_NONE,  2047, 1023, 1, 1, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_STATS, 1,    0,    1, 1, 0, 1, 1,    1023);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  1024, 0,    1, 1, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 1024, 0,    1, 1, 0, 0, 0,    0);
    // carve holes of 50, 200, 20 and 5 units, then free an already free range
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  50,   100,  0, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  200,  300,  0, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  20,   600,  0, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  5,    900,  0, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_FREE,  10,   100,  0, 0, 0, 0, 0,    0);
    add_row(1, bfa_pkg::POL_BEST,  bfa_pkg::OP_ALLOC, 10,   0,    0, 0, 0, 0, 0,    0);
    add_row(1, bfa_pkg::POL_WORST, bfa_pkg::OP_ALLOC, 10,   0,    0, 0, 0, 0, 0,    0);
    add_row(1, bfa_pkg::POL_NONE,  bfa_pkg::OP_ALLOC, 1,    0,    1, 0, 0, 0, 0,    0);
    add_row(1, bfa_pkg::POL_FIRST, bfa_pkg::OP_ALLOC, 3,    0,    0, 0, 0, 0, 0,    0);
    add_row(0, bfa_pkg::POL_FIRST, bfa_pkg::OP_STATS, 1,    0,    0, 0, 0, 0, 0,    0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_pol) write_policy(dir_rows[i].pol);
      issue(dir_rows[i].op, int'(dir_rows[i].size), int'(dir_rows[i].start), r);
      awaited_replies.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
      maybe_gap();
    end

    // Random phases: rebuild a pool of live blocks under each policy
    drain();
    issue(bfa_pkg::OP_FREE, 1024, 0, r);
    awaited_replies.push_back(r);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: phase_pol = bfa_pkg::POL_BEST;
        1: phase_pol = bfa_pkg::POL_WORST;
        2: phase_pol = bfa_pkg::POL_NONE;
        3: phase_pol = bfa_pkg::POL_FIRST;
        default: phase_pol = bfa_pkg::POL_BEST;
      endcase
      phase_len = (phase_pol == bfa_pkg::POL_NONE) ? 20 : 140;
      write_policy(phase_pol);
      for (int n = 0; n < phase_len; n++) begin
        calm = (ph == 3 && n >= 20 && n < 130);
        pick = $urandom_range(0, 99);
        start = $urandom_range(0, MEM_UNITS - 1);
        if (pick < 45 && live_start.size() < 30) begin
          op = bfa_pkg::OP_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 2) size = 0;
          else if (pick < 5) size = $urandom_range(1025, 2047);
          else if (pick < 10) size = $urandom_range(65, 1024);
          else size = $urandom_range(1, 64);
        end else if (pick < 80) begin
          op = bfa_pkg::OP_FREE;
          if (live_start.size() != 0 && $urandom_range(0, 99) < 80) begin
            idx = $urandom_range(0, live_start.size() - 1);
            start = live_start[idx];
            size = live_size[idx];
            // overlap a neighbor now and then
            if ($urandom_range(0, 9) == 0) size += $urandom_range(1, 30);
            live_start.delete(idx);
            live_size.delete(idx);
          end else begin
            pick = $urandom_range(0, 99);
            size = (pick < 10) ? 0 : (pick < 80) ? $urandom_range(1, 128) :
                   $urandom_range(129, 2047);
          end
        end else if (pick < 93) begin
          op = bfa_pkg::OP_STATS;
          size = $urandom_range(0, 2047);
        end else begin
          op = bfa_pkg::OP_NONE;
          size = $urandom_range(0, 2047);
        end
        issue(op, size, start, r);
        awaited_replies.push_back(r);
        if (op == bfa_pkg::OP_ALLOC && r.found) begin
          live_start.push_back(int'(r.alloc_start));
          live_size.push_back(size);
        end
        maybe_gap();
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    $display("covered: %0d placed and %0d refused allocations, %0d frees,",
             n_placed, n_refused, n_free);
    $display("covered: %0d stat reads, %0d no-ops, %0d policy writes incl. the unused code",
             n_stats, n_nop, n_pol_writes);
    if (awaited_replies.size() != 0) begin
      $error("%0d results never arrived", awaited_replies.size());
      errors++;
    end
    if (errors == 0) begin
      $display("bitmap_fit_allocator regression: pass");
    end else begin
      $display("bitmap_fit_allocator regression: fail");
    end
    $finish;
  end

endmodule
